// File: rtl/asl_pkg.sv
// ----------------------------------------------------------------------------
// asl_pkg
// Shared types and constants for the assembly source lexer.
// ----------------------------------------------------------------------------
package asl_pkg;

    // Offset counter width; token fields stay 16 bits and saturate.
    localparam int OFFSET_BITS = 16;

    localparam int TOK_W = 16;

    // Token queue; depth must be a power of two.
    localparam int TOKQ_DEPTH = 4;
    localparam int TOKQ_PTR_W = $clog2(TOKQ_DEPTH);
    localparam int TOKQ_CNT_W = $clog2(TOKQ_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_R_UP  = 8'h52;
    localparam logic [7:0] CH_R_LO  = 8'h72;

    typedef enum logic [2:0] {
        TK_WORD    = 3'd0,
        TK_REG     = 3'd1,
        TK_LABEL   = 3'd2,
        TK_IMM     = 3'd3,
        TK_COMMA   = 3'd4,
        TK_NEWLINE = 3'd5,
        TK_END     = 3'd6,
        TK_INVALID = 3'd7
    } token_kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_WORD = 2'd1,
        MODE_NUM  = 2'd2
    } lex_mode_t;

    typedef struct packed {
        token_kind_t      kind;
        logic [TOK_W-1:0] start;
        logic [TOK_W-1:0] length;
        logic             last;
    } token_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) ||
               (b == CH_VT) || (b == CH_FF);
    endfunction

endpackage

// File: rtl/asl_byte_if.sv
// ----------------------------------------------------------------------------
// asl_byte_if
// Source byte channel: valid/ready plus one byte per word.
// ----------------------------------------------------------------------------
interface asl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink   (input valid, input source_byte, output ready);
endinterface

// File: rtl/asl_token_if.sv
// ----------------------------------------------------------------------------
// asl_token_if
// Token channel: valid/ready plus one token per word.
// ----------------------------------------------------------------------------
interface asl_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_size;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_size, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_size, input last_of_run, output ready);
endinterface

// File: rtl/assembly_source_lexer_core.sv
// ----------------------------------------------------------------------------
// assembly_source_lexer_core
// Streaming assembly lexer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// One source byte is taken per word on src; tokens leave one per word on tok.
// The block accepts a byte every cycle while the queue has room: an accepted
// byte is held in the input register, is lexed there by combinational logic,
// and its tokens enter a four-entry token queue, so the first token of a byte
// shows on tok once it has been written into the queue, whose head drives tok.
// A byte yields zero, one or two tokens (a byte that ends a pending word or
// number first flushes that token, then its own); the two tokens of a byte
// leave on tok one per word, and src.ready drops whenever the queue has fewer
// than two free entries while a byte waits in the input register. last_of_run
// marks the final token of each byte. A zero byte ends the source: it emits an
// end token and restarts offsets at zero. Offsets and lengths saturate at
// 65535.
// ----------------------------------------------------------------------------
module assembly_source_lexer_core (
    input  logic         clk,
    input  logic         rst_n,
    asl_byte_if.sink     src,
    asl_token_if.source  tok
);

    // input register
    logic       byte_vld_reg;
    logic [7:0] byte_reg;

    logic            advance;
    logic            room2;
    logic            q_not_empty;
    logic [1:0]      tok_cnt;
    logic [1:0]      push_cnt;
    asl_pkg::token_t tok0;
    asl_pkg::token_t tok1;
    asl_pkg::token_t head;

    // lex the held byte only when both its tokens fit
    assign advance   = byte_vld_reg && room2;
    assign src.ready = !byte_vld_reg || advance;
    assign push_cnt  = advance ? tok_cnt : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
        end
        else if (src.valid && src.ready)
        begin
            byte_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            byte_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src.valid && src.ready)
        begin
            byte_reg <= src.source_byte;
        end
    end

    asl_lex u_lex (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .byte_in (byte_reg),
        .tok_cnt (tok_cnt),
        .tok0    (tok0),
        .tok1    (tok1)
    );

    asl_tok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push0     (tok0),
        .push1     (tok1),
        .pop       (q_not_empty && tok.ready),
        .head      (head),
        .not_empty (q_not_empty),
        .room2     (room2)
    );

    // output word straight from the queue head
    assign tok.valid        = q_not_empty;
    assign tok.token_kind   = head.kind;
    assign tok.token_start  = head.start;
    assign tok.token_size   = head.length;
    assign tok.last_of_run  = head.last;

endmodule

// File: rtl/asl_lex.sv
// ----------------------------------------------------------------------------
// asl_lex
// Lexer state and per-byte decision; yields zero, one or two tokens per byte.
// ----------------------------------------------------------------------------
module asl_lex (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        byte_in,
    output logic [1:0]        tok_cnt,
    output asl_pkg::token_t   tok0,
    output asl_pkg::token_t   tok1
);

    localparam int OB = asl_pkg::OFFSET_BITS;
    localparam logic [OB-1:0] OFF_MAX = {OB{1'b1}};
    // 65535 seen at offset width + 1; truncation is harmless below 16 bits
    localparam logic [OB:0] SAT16 = (OB + 1)'(17'h0FFFF);

    function automatic logic [15:0] sat16(input logic [OB:0] v);
        return (v > SAT16) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic logic [15:0] len16(input logic [OB:0] v);
        logic [15:0] r;
        r = sat16(v);
        if (v == '0)
        begin
            r = 16'd1;
        end
        return r;
    endfunction

    asl_pkg::lex_mode_t mode_reg, mode_next;
    logic               cand_reg, cand_next;
    logic [OB-1:0]      pstart_reg, pstart_next;
    logic [OB-1:0]      off_reg, off_next;

    logic [OB-1:0]         pos_inc;
    logic [OB-1:0]         plen;
    logic                  lexed;
    logic                  flush_vld;
    asl_pkg::token_kind_t  flush_kind;
    logic                  own_vld;
    asl_pkg::token_kind_t  own_kind;
    logic [15:0]           own_start;
    logic [15:0]           own_len;
    asl_pkg::token_t       flush_tok;
    asl_pkg::token_t       own_tok;

    assign pos_inc = (off_reg == OFF_MAX) ? OFF_MAX : off_reg + 1'b1;
    assign plen    = (off_reg >= pstart_reg) ? off_reg - pstart_reg : '0;

    always_comb
    begin
        mode_next   = mode_reg;
        cand_next   = cand_reg;
        pstart_next = pstart_reg;
        off_next    = (byte_in == asl_pkg::CH_NUL) ? '0 : pos_inc;
        lexed       = 1'b0;
        flush_vld   = 1'b0;
        flush_kind  = asl_pkg::TK_WORD;
        own_vld     = 1'b0;
        own_kind    = asl_pkg::TK_INVALID;
        own_start   = sat16({1'b0, off_reg});
        own_len     = 16'd1;

        case (mode_reg)
            asl_pkg::MODE_WORD:
            begin
                if (asl_pkg::is_alpha(byte_in) || asl_pkg::is_digit(byte_in) ||
                    (byte_in == asl_pkg::CH_UNDER))
                begin
                    lexed = 1'b1;
                    if (!asl_pkg::is_digit(byte_in))
                    begin
                        cand_next = 1'b0;
                    end
                end
                else if (byte_in == asl_pkg::CH_COLON)
                begin
                    // label: colon counted in the length
                    lexed     = 1'b1;
                    own_vld   = 1'b1;
                    own_kind  = asl_pkg::TK_LABEL;
                    own_start = sat16({1'b0, pstart_reg});
                    own_len   = len16({1'b0, plen} + 1'b1);
                    mode_next = asl_pkg::MODE_IDLE;
                    cand_next = 1'b0;
                end
                else
                begin
                    flush_vld  = 1'b1;
                    flush_kind = (cand_reg && (plen >= OB'(2))) ?
                                 asl_pkg::TK_REG : asl_pkg::TK_WORD;
                    mode_next  = asl_pkg::MODE_IDLE;
                    cand_next  = 1'b0;
                end
            end
            asl_pkg::MODE_NUM:
            begin
                if (asl_pkg::is_digit(byte_in))
                begin
                    lexed = 1'b1;
                end
                else
                begin
                    flush_vld  = 1'b1;
                    flush_kind = asl_pkg::TK_IMM;
                    mode_next  = asl_pkg::MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = asl_pkg::MODE_IDLE;
            end
        endcase

        // byte lexed on its own
        if (!lexed)
        begin
            if (asl_pkg::is_blank(byte_in))
            begin
                own_vld = 1'b0;
            end
            else if (asl_pkg::is_alpha(byte_in))
            begin
                mode_next   = asl_pkg::MODE_WORD;
                cand_next   = (byte_in == asl_pkg::CH_R_LO) || (byte_in == asl_pkg::CH_R_UP);
                pstart_next = off_reg;
            end
            else if (asl_pkg::is_digit(byte_in))
            begin
                mode_next   = asl_pkg::MODE_NUM;
                pstart_next = off_reg;
            end
            else
            begin
                own_vld = 1'b1;
                case (byte_in)
                    asl_pkg::CH_COMMA: own_kind = asl_pkg::TK_COMMA;
                    asl_pkg::CH_LF:    own_kind = asl_pkg::TK_NEWLINE;
                    asl_pkg::CH_NUL:   own_kind = asl_pkg::TK_END;
                    default:           own_kind = asl_pkg::TK_INVALID;
                endcase
            end
        end
    end

    always_comb
    begin
        flush_tok.kind   = flush_kind;
        flush_tok.start  = sat16({1'b0, pstart_reg});
        flush_tok.length = len16({1'b0, plen});
        flush_tok.last   = !own_vld;

        own_tok.kind     = own_kind;
        own_tok.start    = own_start;
        own_tok.length   = own_len;
        own_tok.last     = 1'b1;

        tok_cnt = 2'(flush_vld) + 2'(own_vld);
        tok0    = flush_vld ? flush_tok : own_tok;
        tok1    = own_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= asl_pkg::MODE_IDLE;
            cand_reg   <= 1'b0;
            pstart_reg <= '0;
            off_reg    <= '0;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            cand_reg   <= cand_next;
            pstart_reg <= pstart_next;
            off_reg    <= off_next;
        end
    end

endmodule

// File: rtl/asl_tok_fifo.sv
// ----------------------------------------------------------------------------
// asl_tok_fifo
// Small token queue; takes up to two tokens a cycle, gives one.
// ----------------------------------------------------------------------------
module asl_tok_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  asl_pkg::token_t   push0,
    input  asl_pkg::token_t   push1,
    input  logic              pop,
    output asl_pkg::token_t   head,
    output logic              not_empty,
    output logic              room2
);

    localparam int PW = asl_pkg::TOKQ_PTR_W;
    localparam int CW = asl_pkg::TOKQ_CNT_W;

    asl_pkg::token_t q_mem [asl_pkg::TOKQ_DEPTH];

    logic [PW-1:0] wr_reg, wr_next;
    logic [PW-1:0] rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign not_empty = (cnt_reg != '0);
    assign room2     = (cnt_reg <= CW'(asl_pkg::TOKQ_DEPTH - 2));
    assign head      = q_mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg + PW'(push_cnt);
        rd_next  = rd_reg + PW'(pop);
        cnt_next = cnt_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            q_mem[wr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            q_mem[wr_reg + 1'b1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// File: rtl/asl_checker.sv
// ----------------------------------------------------------------------------
// asl_checker
// Port-level checks on the lexer's token stream.
// ----------------------------------------------------------------------------
module asl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        tok_valid,
    input logic        tok_ready,
    input logic [2:0]  token_kind,
    input logic [15:0] token_start,
    input logic [15:0] token_size,
    input logic        last_of_run
);

    // a stalled word holds
    a_tok_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !tok_ready |=> tok_valid && $stable(token_kind) &&
        $stable(token_start) && $stable(token_size) && $stable(last_of_run))
        else $error("token changed while stalled");

    // both tokens of a byte are queued together
    a_run_follows: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && tok_ready && !last_of_run |=> tok_valid)
        else $error("flushed token not followed by its byte token");

    // single-byte tokens
    a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && (token_kind == asl_pkg::TK_COMMA ||
                      token_kind == asl_pkg::TK_NEWLINE ||
                      token_kind == asl_pkg::TK_END ||
                      token_kind == asl_pkg::TK_INVALID) |-> token_size == 16'd1)
        else $error("one-byte token with wrong length");

    // r plus at least one digit
    a_reg_len: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && token_kind == asl_pkg::TK_REG |-> token_size >= 16'd2)
        else $error("register token too short");

    // only flushed word/number tokens may be non-final
    a_flush_kind: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid && !last_of_run |-> token_kind == asl_pkg::TK_WORD ||
        token_kind == asl_pkg::TK_REG || token_kind == asl_pkg::TK_IMM)
        else $error("non-final token of unexpected kind");

endmodule

bind assembly_source_lexer_core asl_checker u_asl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .tok_valid    (tok.valid),
    .tok_ready    (tok.ready),
    .token_kind   (tok.token_kind),
    .token_start  (tok.token_start),
    .token_size   (tok.token_size),
    .last_of_run  (tok.last_of_run)
);

// File: sim/tb_assembly_source_lexer_core.sv
// ----------------------------------------------------------------------------
// tb_assembly_source_lexer_core
// Self-checking bench for the streaming assembly source lexer.
// ----------------------------------------------------------------------------
// Source bytes go in on src and tokens come back on tok. A behavioral lexer
// in the bench follows every accepted byte and queues the tokens it should
// cause; each token taken from tok is compared field by field with the oldest
// queued one. The run has three parts: a directed table from reset, random
// source lines mixed with noise, and a final drain. Both sides idle and stall
// at random.
// ----------------------------------------------------------------------------
module tb_assembly_source_lexer_core;
    import asl_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 16;
    // Source bytes sent in the random part.
    localparam int RANDOM_ITEMS = 420;

    localparam longint unsigned OFFSET_MAX = (64'd1 << OFFSET_BITS) - 1;
    localparam longint unsigned FIELD_MAX  = (64'd1 << TOK_W) - 1;

    // Byte classes as the lexer sees them.
    typedef enum logic [2:0] {
        CC_BLANK,
        CC_ALPHA,
        CC_DIGIT,
        CC_UNDER,
        CC_COLON,
        CC_OTHER
    } char_class_t;

    // One row of the directed table. With known set, t0/t1 hold the n tokens
    // typed in by hand; otherwise the lexer model supplies them.
    typedef struct packed {
        logic [7:0] b;
        logic       known;
        logic [1:0] n;
        token_t     t0;
        token_t     t1;
    } stim_row_t;

    logic clk;
    logic rst_n;

    asl_byte_if  src_if ();
    asl_token_if tok_if ();

    assembly_source_lexer_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .src   (src_if),
        .tok   (tok_if)
    );

    // Model state of the lexer.
    lex_mode_t       lx_mode;
    bit              lx_reg_cand;
    longint unsigned lx_pend_start;
    longint unsigned lx_offset;

    token_t tokens_due[$];

    int  errors;
    int  cycles;
    int  bytes_sent;
    int  items_sent;
    int  tokens_seen;
    bit  idle_en;

    // ------------------------------------------------------------------------
    // Clock, reset, cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d tokens still due", cycles,
                     tokens_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Lexer model
    // ------------------------------------------------------------------------
    function automatic char_class_t classify(input logic [7:0] b);
        if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_VT || b == CH_FF)
            return CC_BLANK;
        if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z"))
            return CC_ALPHA;
        if (b >= "0" && b <= "9")
            return CC_DIGIT;
        if (b == CH_UNDER)
            return CC_UNDER;
        if (b == CH_COLON)
            return CC_COLON;
        return CC_OTHER;
    endfunction

    // Zero length only shows up once the offset has saturated; report it as 1.
    function automatic token_t make_token(input token_kind_t kind,
                                          input longint unsigned start,
                                          input longint unsigned len,
                                          input bit last);
        token_t t;
        if (len == 0)
            len = 1;
        t.kind   = kind;
        t.start  = (start > FIELD_MAX) ? '1 : start[TOK_W-1:0];
        t.length = (len > FIELD_MAX) ? '1 : len[TOK_W-1:0];
        t.last   = last;
        return t;
    endfunction

    // Advance the model by one byte; queue its tokens when queue_them is set.
    task automatic lex_byte(input logic [7:0] b, input bit queue_them);
        char_class_t     cc;
        longint unsigned pos;
        longint unsigned nxt;
        longint unsigned plen;
        token_kind_t     kind;
        token_t          toks[$];
        bit              absorbed;

        cc       = classify(b);
        pos      = lx_offset;
        nxt      = (pos < OFFSET_MAX) ? pos + 1 : OFFSET_MAX;
        plen     = (pos >= lx_pend_start) ? pos - lx_pend_start : 0;
        absorbed = 1'b0;

        // A pending word or number either grows or is flushed first.
        if (lx_mode == MODE_WORD)
        begin
            if (cc == CC_ALPHA || cc == CC_DIGIT || cc == CC_UNDER)
            begin
                if (cc != CC_DIGIT)
                    lx_reg_cand = 1'b0;
                absorbed = 1'b1;
            end
            else
            begin
                if (cc == CC_COLON)
                begin
                    toks.push_back(make_token(TK_LABEL, lx_pend_start, plen + 1, 1'b0));
                    absorbed = 1'b1;
                end
                else
                begin
                    kind = (lx_reg_cand && plen >= 2) ? TK_REG : TK_WORD;
                    toks.push_back(make_token(kind, lx_pend_start, plen, 1'b0));
                end
                lx_mode     = MODE_IDLE;
                lx_reg_cand = 1'b0;
            end
        end
        else if (lx_mode == MODE_NUM)
        begin
            if (cc == CC_DIGIT)
                absorbed = 1'b1;
            else
            begin
                toks.push_back(make_token(TK_IMM, lx_pend_start, plen, 1'b0));
                lx_mode = MODE_IDLE;
            end
        end

        if (absorbed)
            lx_offset = nxt;
        else
        begin
            case (cc)
                CC_BLANK: ;
                CC_ALPHA:
                begin
                    lx_mode       = MODE_WORD;
                    lx_reg_cand   = (b == CH_R_UP || b == CH_R_LO);
                    lx_pend_start = pos;
                end
                CC_DIGIT:
                begin
                    lx_mode       = MODE_NUM;
                    lx_pend_start = pos;
                end
                default:
                begin
                    if (b == CH_COMMA)
                        kind = TK_COMMA;
                    else if (b == CH_LF)
                        kind = TK_NEWLINE;
                    else if (b == CH_NUL)
                        kind = TK_END;
                    else
                        kind = TK_INVALID;
                    toks.push_back(make_token(kind, pos, 1, 1'b0));
                end
            endcase
            lx_offset = (b == CH_NUL) ? 0 : nxt;
        end

        if (toks.size() > 0)
            toks[toks.size()-1].last = 1'b1;
        if (queue_them)
            foreach (toks[i])
                tokens_due.push_back(toks[i]);
    endtask

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------
    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Offer one byte and hold it until the word is taken.
    task automatic send_byte(input logic [7:0] b, input bit use_model = 1'b1);
        int gap;
        gap = (idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            src_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_if.valid       <= 1'b1;
        src_if.source_byte <= b;
        do
            @(posedge clk);
        while (!src_if.ready);
        bytes_sent++;
        if (classify(b) != CC_BLANK)
            items_sent++;
        lex_byte(b, use_model);
    endtask

    task automatic wait_drained();
        while (tokens_due.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1))
            return 8'("a" + $urandom_range(0, 25));
        return 8'("A" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 9))
            6:       return CH_TAB;
            7:       return CH_CR;
            8:       return CH_VT;
            9:       return CH_FF;
            default: return CH_SPACE;
        endcase
    endfunction

    task automatic send_blanks(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) send_byte(rand_blank());
    endtask

    // Letter first, then letters, digits and underscores.
    task automatic send_word(input int len);
        send_byte(rand_letter());
        repeat (len - 1)
        begin
            case ($urandom_range(0, 5))
                0:       send_byte(rand_digit());
                1:       send_byte(CH_UNDER);
                default: send_byte(rand_letter());
            endcase
        end
    endtask

    task automatic send_number(input int len);
        repeat (len) send_byte(rand_digit());
    endtask

    task automatic send_register();
        int n;
        n = $urandom_range(1, 3);
        send_byte($urandom_range(0, 1) ? CH_R_LO : CH_R_UP);
        send_number(n);
    endtask

    // label:  mnemonic  op, op, op  then newline (now and then end of source)
    task automatic send_line();
        int nops;
        if ($urandom_range(0, 3) == 0)
        begin
            send_word($urandom_range(1, 8));
            send_byte(CH_COLON);
            send_blanks(0, 2);
        end
        send_word($urandom_range(1, 5));
        nops = $urandom_range(0, 3);
        for (int i = 0; i < nops; i++)
        begin
            if (i == 0)
                send_blanks(1, 2);
            else
            begin
                send_blanks(0, 1);
                send_byte(CH_COMMA);
                send_blanks(0, 1);
            end
            case ($urandom_range(0, 7))
                0, 1, 2: send_register();
                3, 4:    send_number($urandom_range(1, 5));
                5:       send_word($urandom_range(1, 6));
                // bare r, and r-digits running on into a letter: plain words
                6:       send_byte($urandom_range(0, 1) ? CH_R_LO : CH_R_UP);
                default:
                begin
                    send_register();
                    send_byte(rand_letter());
                end
            endcase
        end
        send_blanks(0, 1);
        send_byte(($urandom_range(0, 9) == 0) ? CH_NUL : CH_LF);
    endtask

    // Raw bytes and broken constructs.
    task automatic send_noise();
        int n;
        case ($urandom_range(0, 4))
            0:
            begin
                send_number($urandom_range(1, 3));
                send_byte(CH_COLON);
            end
            1:
            begin
                send_blanks(0, 1);
                send_byte(CH_COLON);
            end
            2:
            begin
                send_number($urandom_range(1, 3));
                send_word($urandom_range(1, 3));
                send_byte(8'($urandom_range(128, 255)));
            end
            default:
            begin
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Receiver side: random stalls on ready, every taken word checked
    // ------------------------------------------------------------------------
    initial
    begin
        int     stall_left;
        token_t want;
        stall_left = 0;
        tok_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && tok_if.valid && tok_if.ready)
            begin
                tokens_seen++;
                if (tokens_due.size() == 0)
                begin
                    $error("token with none due: kind %0d start %0d length %0d",
                           tok_if.token_kind, tok_if.token_start, tok_if.token_size);
                    errors++;
                end
                else
                begin
                    want = tokens_due.pop_front();
                    if (tok_if.token_kind !== want.kind)
                    begin
                        $error("token_kind: expected %0d, got %0d", want.kind,
                               tok_if.token_kind);
                        errors++;
                    end
                    if (tok_if.token_start !== want.start)
                    begin
                        $error("token_start: expected %0d, got %0d", want.start,
                               tok_if.token_start);
                        errors++;
                    end
                    if (tok_if.token_size !== want.length)
                    begin
                        $error("token_size: expected %0d, got %0d", want.length,
                               tok_if.token_size);
                        errors++;
                    end
                    if (tok_if.last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0d, got %0d", want.last,
                               tok_if.last_of_run);
                        errors++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                tok_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                tok_if.ready <= 1'b1;
                if (idle_en && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        stim_row_t dir_rows[$];
        int        line_no;
        int        rand_goal;

        errors      = 0;
        cycles      = 0;
        bytes_sent  = 0;
        items_sent  = 0;
        tokens_seen = 0;
        idle_en     = 1'b1;

        lx_mode       = MODE_IDLE;
        lx_reg_cand   = 1'b0;
        lx_pend_start = 0;
        lx_offset     = 0;

        src_if.valid       <= 1'b0;
        src_if.source_byte <= 8'h00;

        // Directed table. Offsets: row 0 sits at 0 and restarts the count, so
        // row k (1 <= k <= 23) sits at offset k-1; row 23 restarts it again.
        // end of source right after reset
        dir_rows.push_back('{CH_NUL, 1'b1, 2'd1, make_token(TK_END, 0, 1, 1), '0});
        dir_rows.push_back('{CH_COMMA, 1'b1, 2'd1, make_token(TK_COMMA, 0, 1, 1), '0});
        dir_rows.push_back('{CH_LF, 1'b1, 2'd1, make_token(TK_NEWLINE, 1, 1, 1), '0});
        // lone colon, then the top byte values
        dir_rows.push_back('{CH_COLON, 1'b1, 2'd1, make_token(TK_INVALID, 2, 1, 1), '0});
        dir_rows.push_back('{8'hFF, 1'b1, 2'd1, make_token(TK_INVALID, 3, 1, 1), '0});
        dir_rows.push_back('{8'h80, 1'b1, 2'd1, make_token(TK_INVALID, 4, 1, 1), '0});
        // r9, : register flushed ahead of the comma
        dir_rows.push_back('{CH_R_LO, 1'b0, 2'd0, '0, '0});
        dir_rows.push_back('{8'("9"), 1'b0, 2'd0, '0, '0});
        dir_rows.push_back('{CH_COMMA, 1'b0, 2'd0, '0, '0});
        // R0: : label, colon counted
        dir_rows.push_back('{CH_R_UP, 1'b0, 2'd0, '0, '0});
        dir_rows.push_back('{8'("0"), 1'b0, 2'd0, '0, '0});
        dir_rows.push_back('{CH_COLON, 1'b0, 2'd0, '0, '0});
        // z_ then space: word with underscore
        dir_rows.push_back('{8'("z"), 1'b0, 2'd0, '0, '0});
        dir_rows.push_back('{CH_UNDER, 1'b0, 2'd0, '0, '0});
        dir_rows.push_back('{CH_SPACE, 1'b0, 2'd0, '0, '0});
        // number then colon: immediate, then invalid colon
        dir_rows.push_back('{8'("0"), 1'b0, 2'd0, '0, '0});
        dir_rows.push_back('{8'("7"), 1'b0, 2'd0, '0, '0});
        dir_rows.push_back('{CH_COLON, 1'b1, 2'd2, make_token(TK_IMM, 14, 2, 0),
                             make_token(TK_INVALID, 16, 1, 1)});
        // number then letter: immediate, then a word starts
        dir_rows.push_back('{8'("5"), 1'b0, 2'd0, '0, '0});
        dir_rows.push_back('{8'("A"), 1'b0, 2'd0, '0, '0});
        dir_rows.push_back('{CH_R_LO, 1'b0, 2'd0, '0, '0});
        dir_rows.push_back('{CH_TAB, 1'b0, 2'd0, '0, '0});
        // bare r closed by end of source: word, then end
        dir_rows.push_back('{CH_R_LO, 1'b0, 2'd0, '0, '0});
        dir_rows.push_back('{CH_NUL, 1'b1, 2'd2, make_token(TK_WORD, 21, 1, 0),
                             make_token(TK_END, 22, 1, 1)});
        dir_rows.push_back('{CH_VT, 1'b0, 2'd0, '0, '0});

        @(posedge rst_n);
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].b, !dir_rows[i].known);
            if (dir_rows[i].known && dir_rows[i].n >= 1)
                tokens_due.push_back(dir_rows[i].t0);
            if (dir_rows[i].known && dir_rows[i].n == 2)
                tokens_due.push_back(dir_rows[i].t1);
        end

        // Sender holds off until the directed tokens are all back.
        src_if.valid <= 1'b0;
        wait_drained();
        @(posedge clk);

        // Random lines, a share of noise, idling switched on and off in stretches.
        rand_goal = bytes_sent + RANDOM_ITEMS;
        line_no   = 0;
        while (bytes_sent < rand_goal)
        begin
            if (line_no % 16 == 0)
                idle_en = ($urandom_range(0, 3) != 0);
            if (line_no % 60 == 59)
            begin
                src_if.valid <= 1'b0;
                wait_drained();
                @(posedge clk);
            end
            if ($urandom_range(0, 5) == 0)
                send_noise();
            else
                send_line();
            line_no++;
        end
        src_if.valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d source bytes (%0d non-blank), %0d tokens compared, %0d cycles.",
                 bytes_sent, items_sent, tokens_seen, cycles);
        $display("Directed table from reset, then random lines with noise, idling and stalls.");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: assembly_source_lexer_core.f
rtl/asl_pkg.sv
rtl/asl_byte_if.sv
rtl/asl_token_if.sv
rtl/asl_lex.sv
rtl/asl_tok_fifo.sv
rtl/assembly_source_lexer_core.sv
rtl/asl_checker.sv
sim/tb_assembly_source_lexer_core.sv
